FILE: src/clpw_pkg.sv
// shared types, constants and command codes for the character lcd writer
`default_nettype none
package clpw_pkg;

	// default characters on one display line
	localparam int LINE_CHARS_DEF = 16;

	// field widths
	localparam int STROBE_W = 8;
	localparam int WAIT_W   = 15;
	localparam int HOLD_W   = 16;
	localparam int CODE_W   = 8;
	localparam int IDX_W    = 3;
	localparam int MAX_WR   = 4;
	localparam int WR_IDX_W = $clog2(MAX_WR);

	// register select levels
	localparam logic RS_INST = 1'b0;
	localparam logic RS_DATA = 1'b1;

	// request kinds
	localparam logic REQ_INIT = 1'b0;
	localparam logic REQ_CHAR = 1'b1;

	// instruction codes
	localparam logic [CODE_W-1:0] CMD_FUNC  = 8'h38;
	localparam logic [CODE_W-1:0] CMD_DISP  = 8'h0C;
	localparam logic [CODE_W-1:0] CMD_CLEAR = 8'h01;
	localparam logic [CODE_W-1:0] CMD_HOME  = 8'h02;
	localparam logic [CODE_W-1:0] CMD_ADDR  = 8'h80;
	localparam logic [CODE_W-1:0] LINE_TWO  = 8'h40;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_STROBE     = 3'd0;
	localparam logic [IDX_W-1:0] REG_CHAR_WAIT  = 3'd1;
	localparam logic [IDX_W-1:0] REG_CLEAR_WAIT = 3'd2;
	localparam logic [IDX_W-1:0] REG_LINE_WAIT  = 3'd3;
	localparam logic [IDX_W-1:0] REG_INIT_WAIT  = 3'd4;

	// configuration reset values
	localparam logic [STROBE_W-1:0] STROBE_RST     = 8'd1;
	localparam logic [WAIT_W-1:0]   CHAR_WAIT_RST  = 15'd50;
	localparam logic [WAIT_W-1:0]   CLEAR_WAIT_RST = 15'd1000;
	localparam logic [WAIT_W-1:0]   LINE_WAIT_RST  = 15'd2000;
	localparam logic [WAIT_W-1:0]   INIT_WAIT_RST  = 15'd1000;

	// phases of one bus write
	localparam logic [1:0] PH_SETUP  = 2'd0;
	localparam logic [1:0] PH_STROBE = 2'd1;
	localparam logic [1:0] PH_HOLD   = 2'd2;

	// one bus write
	typedef struct packed {
		logic              rs;
		logic [CODE_W-1:0] code;
		logic [WAIT_W-1:0] wait_us;
	} wr_t;

	// all bus writes of one request
	typedef struct packed {
		wr_t [MAX_WR-1:0]    wr;
		logic [WR_IDX_W-1:0] last_idx;
		logic [CODE_W-1:0]   prev_bus;
	} plan_t;

	// configuration registers
	typedef struct packed {
		logic [STROBE_W-1:0] strobe_us;
		logic [WAIT_W-1:0]   char_wait_us;
		logic [WAIT_W-1:0]   clear_wait_us;
		logic [WAIT_W-1:0]   line_wait_us;
		logic [WAIT_W-1:0]   init_wait_us;
	} cfg_t;

endpackage
`default_nettype wire

FILE: src/char_lcd_parallel_writer_top.sv
// top level of the 8-bit parallel character lcd writer
// Requests enter on the s_ stream: s_tuser is the request kind (init sequence or
// one character), s_tdata carries the character code and the frame start flag.
// Each request turns into 1 to 4 bus writes, each write into three pin phases
// (setup, enable high, enable low with hold), and every phase leaves as one
// beat on the m_ stream with the pin levels and the hold time in microseconds.
// m_tlast marks the final phase of a request.
// A request's first phase goes through the item register, then the result register.
// Throughput: one phase per cycle while the receiver does not stall, so a request is
// 3 phases (plain character), 6 phases (character after a clear or line-two command)
// or 12 phases (init sequence); the phase counter over the held write list sets this.
// The next request is taken in the cycle its predecessor's last phase moves into
// the result register, so requests follow without a gap.
// When the receiver stalls, the result register holds its beat and the sequencer
// waits; a new request is then taken only once the held one is done.
// Configuration writes (cfg_ channel) are always accepted and must only arrive
// while the block is idle. Reset clears the registers to their defaults, the
// bus value to zero and the frame position to the start.
`default_nettype none
module char_lcd_parallel_writer_top #(
	parameter int LINE_CHARS = clpw_pkg::LINE_CHARS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	// request channel
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [15:0] s_tdata,   // [7:0] char_code, [8] frame_start, rest zero
	input  wire  [0:0]  s_tuser,   // [0] req_type
	// phase channel
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata,   // [0] reg_select, [1] read_not_write,
	                               // [2] enable_pin, [10:3] bus_byte,
	                               // [26:11] hold_us, rest zero
	output logic        m_tlast,   // last
	// configuration channel
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [clpw_pkg::IDX_W-1:0]  cfg_index,
	input  wire  [clpw_pkg::WAIT_W-1:0] cfg_data
);

	clpw_pkg::cfg_t                 cfg_q;
	clpw_pkg::plan_t                plan;
	logic                           accept;
	logic                           out_rs;
	logic                           out_en;
	logic [clpw_pkg::CODE_W-1:0]    out_bus;
	logic [clpw_pkg::HOLD_W-1:0]    out_hold;

	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.strobe_us     <= clpw_pkg::STROBE_RST;
			cfg_q.char_wait_us  <= clpw_pkg::CHAR_WAIT_RST;
			cfg_q.clear_wait_us <= clpw_pkg::CLEAR_WAIT_RST;
			cfg_q.line_wait_us  <= clpw_pkg::LINE_WAIT_RST;
			cfg_q.init_wait_us  <= clpw_pkg::INIT_WAIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				clpw_pkg::REG_STROBE:     cfg_q.strobe_us <= cfg_data[clpw_pkg::STROBE_W-1:0];
				clpw_pkg::REG_CHAR_WAIT:  cfg_q.char_wait_us  <= cfg_data;
				clpw_pkg::REG_CLEAR_WAIT: cfg_q.clear_wait_us <= cfg_data;
				clpw_pkg::REG_LINE_WAIT:  cfg_q.line_wait_us  <= cfg_data;
				clpw_pkg::REG_INIT_WAIT:  cfg_q.init_wait_us  <= cfg_data;
				default: ;
			endcase
		end
	end

	// request decode and carried state
	clpw_plan #(
		.LINE_CHARS (LINE_CHARS)
	) u_plan (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.req_type    (s_tuser[0]),
		.char_code   (s_tdata[7:0]),
		.frame_start (s_tdata[8]),
		.cfg         (cfg_q),
		.plan        (plan)
	);

	// phase sequencer with result register
	clpw_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.plan_in   (plan),
		.strobe_us (cfg_q.strobe_us),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_rs    (out_rs),
		.out_en    (out_en),
		.out_bus   (out_bus),
		.out_hold  (out_hold),
		.out_last  (m_tlast)
	);

	// pack the phase beat, read_not_write is always low
	assign m_tdata = {5'd0, out_hold, out_bus, out_en, 1'b0, out_rs};

endmodule
`default_nettype wire

FILE: src/clpw_plan.sv
// request decoder: builds the list of bus writes and tracks position and bus value
`default_nettype none
module clpw_plan #(
	parameter int LINE_CHARS = clpw_pkg::LINE_CHARS_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            accept,
	input  wire                            req_type,
	input  wire [clpw_pkg::CODE_W-1:0]     char_code,
	input  wire                            frame_start,
	input  clpw_pkg::cfg_t                 cfg,
	output clpw_pkg::plan_t                plan
);

	localparam int POS_W = $clog2(2 * LINE_CHARS + 1);
	localparam logic [POS_W-1:0] LINE_POS = POS_W'(LINE_CHARS);
	localparam logic [POS_W-1:0] FULL_POS = POS_W'(2 * LINE_CHARS);

	logic [POS_W-1:0]            frame_pos_q;
	logic [clpw_pkg::CODE_W-1:0] bus_value_q;
	logic [POS_W-1:0]            pos_eff;
	logic [POS_W-1:0]            pos_next;
	logic                        line_cmd;
	clpw_pkg::wr_t               w_clear;
	clpw_pkg::wr_t               w_line;
	clpw_pkg::wr_t               w_char;
	clpw_pkg::wr_t               w_init_last;

	// position seen by this character and position after it
	assign pos_eff  = frame_start ? '0 : frame_pos_q;
	assign line_cmd = (pos_eff == LINE_POS);
	assign pos_next = (pos_eff < FULL_POS) ? pos_eff + POS_W'(1) : pos_eff;

	assign w_clear     = '{rs: clpw_pkg::RS_INST, code: clpw_pkg::CMD_CLEAR,
		wait_us: cfg.clear_wait_us};
	assign w_line      = '{rs: clpw_pkg::RS_INST,
		code: clpw_pkg::CMD_ADDR | clpw_pkg::LINE_TWO, wait_us: cfg.line_wait_us};
	assign w_char      = '{rs: clpw_pkg::RS_DATA, code: char_code,
		wait_us: cfg.char_wait_us};
	assign w_init_last = '{rs: clpw_pkg::RS_INST, code: clpw_pkg::CMD_HOME,
		wait_us: cfg.init_wait_us};

	// write list for this request
	always_comb begin
		plan          = '0;
		plan.prev_bus = bus_value_q;
		if (req_type == clpw_pkg::REQ_INIT) begin
			plan.wr[0]    = '{rs: clpw_pkg::RS_INST, code: clpw_pkg::CMD_FUNC,
				wait_us: cfg.init_wait_us};
			plan.wr[1]    = '{rs: clpw_pkg::RS_INST, code: clpw_pkg::CMD_DISP,
				wait_us: cfg.init_wait_us};
			plan.wr[2]    = '{rs: clpw_pkg::RS_INST, code: clpw_pkg::CMD_CLEAR,
				wait_us: cfg.init_wait_us};
			plan.wr[3]    = w_init_last;
			plan.last_idx = clpw_pkg::WR_IDX_W'(3);
		end else if (frame_start) begin
			plan.wr[0]    = w_clear;
			plan.wr[1]    = w_char;
			plan.last_idx = clpw_pkg::WR_IDX_W'(1);
		end else if (line_cmd) begin
			plan.wr[0]    = w_line;
			plan.wr[1]    = w_char;
			plan.last_idx = clpw_pkg::WR_IDX_W'(1);
		end else begin
			plan.wr[0]    = w_char;
			plan.last_idx = '0;
		end
	end

	// state carried from one request to the next
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_pos_q <= '0;
			bus_value_q <= '0;
		end else if (accept) begin
			if (req_type == clpw_pkg::REQ_INIT) begin
				bus_value_q <= clpw_pkg::CMD_HOME;
			end else begin
				bus_value_q <= char_code;
				frame_pos_q <= pos_next;
			end
		end
	end

endmodule
`default_nettype wire

FILE: src/clpw_seq.sv
// phase sequencer: holds one write list and emits one pin phase per beat
`default_nettype none
module clpw_seq (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  clpw_pkg::plan_t                  plan_in,
	input  wire [clpw_pkg::STROBE_W-1:0]     strobe_us,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic                             out_rs,
	output logic                             out_en,
	output logic [clpw_pkg::CODE_W-1:0]      out_bus,
	output logic [clpw_pkg::HOLD_W-1:0]      out_hold,
	output logic                             out_last
);

	clpw_pkg::plan_t                 plan_q;
	logic                            item_valid_q;
	logic [clpw_pkg::WR_IDX_W-1:0]   widx_q;
	logic [1:0]                      ph_q;
	logic                            out_valid_q;
	logic                            out_rs_q;
	logic                            out_en_q;
	logic [clpw_pkg::CODE_W-1:0]     out_bus_q;
	logic [clpw_pkg::HOLD_W-1:0]     out_hold_q;
	logic                            out_last_q;

	logic                            emit;
	logic                            fin;
	logic                            load;
	clpw_pkg::wr_t                   cur;
	logic [clpw_pkg::CODE_W-1:0]     prev_byte;
	logic [clpw_pkg::STROBE_W-1:0]   s_eff;
	logic                            ph_en;
	logic [clpw_pkg::CODE_W-1:0]     ph_bus;
	logic [clpw_pkg::HOLD_W-1:0]     ph_hold;

	// handshake between item register and result register
	assign emit     = item_valid_q && (!out_valid_q || out_ready);
	assign fin      = (ph_q == clpw_pkg::PH_HOLD) && (widx_q == plan_q.last_idx);
	assign in_ready = !item_valid_q || (emit && fin);
	assign load     = in_valid && in_ready;

	// current write and the byte left on the bus before it
	assign cur       = plan_q.wr[widx_q];
	assign prev_byte = (widx_q == '0) ? plan_q.prev_bus
		: plan_q.wr[widx_q - clpw_pkg::WR_IDX_W'(1)].code;
	assign s_eff     = (strobe_us == '0) ? clpw_pkg::STROBE_W'(1) : strobe_us;

	// pin levels and hold for the current phase
	always_comb begin
		case (ph_q)
			clpw_pkg::PH_SETUP: begin
				ph_en   = 1'b0;
				ph_bus  = prev_byte;
				ph_hold = clpw_pkg::HOLD_W'(s_eff);
			end
			clpw_pkg::PH_STROBE: begin
				ph_en   = 1'b1;
				ph_bus  = cur.code;
				ph_hold = clpw_pkg::HOLD_W'(s_eff);
			end
			default: begin
				ph_en   = 1'b0;
				ph_bus  = cur.code;
				ph_hold = clpw_pkg::HOLD_W'(s_eff) + clpw_pkg::HOLD_W'(cur.wait_us);
			end
		endcase
	end

	// item register payload
	always_ff @(posedge clk) begin
		if (load) begin
			plan_q <= plan_in;
		end
	end

	// item occupancy and phase counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_q <= 1'b0;
			widx_q       <= '0;
			ph_q         <= clpw_pkg::PH_SETUP;
		end else if (load) begin
			item_valid_q <= 1'b1;
			widx_q       <= '0;
			ph_q         <= clpw_pkg::PH_SETUP;
		end else if (emit) begin
			if (fin) begin
				item_valid_q <= 1'b0;
			end
			if (ph_q == clpw_pkg::PH_HOLD) begin
				ph_q   <= clpw_pkg::PH_SETUP;
				widx_q <= widx_q + clpw_pkg::WR_IDX_W'(1);
			end else begin
				ph_q <= ph_q + 2'd1;
			end
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_rs_q   <= cur.rs;
			out_en_q   <= ph_en;
			out_bus_q  <= ph_bus;
			out_hold_q <= ph_hold;
			out_last_q <= fin;
		end
	end

	assign out_valid = out_valid_q;
	assign out_rs    = out_rs_q;
	assign out_en    = out_en_q;
	assign out_bus   = out_bus_q;
	assign out_hold  = out_hold_q;
	assign out_last  = out_last_q;

endmodule
`default_nettype wire
